// ===== sv/mpid_pkg.sv =====
// Shared widths, codes and saturation helper for the multichannel PID block.
package mpid_pkg;

  localparam int unsigned DataW   = 32;
  localparam int unsigned ChanW   = 3;
  localparam int unsigned DtW     = 16;
  localparam int unsigned LimW    = 31;
  localparam int unsigned RegIdxW = 2;
  // wide enough for a gain product shifted down, plus the three-term sum
  localparam int unsigned SumW    = 50;

  typedef enum logic {
    CmdStep  = 1'b0,
    CmdClear = 1'b1
  } cmd_e;

  typedef enum logic [RegIdxW-1:0] {
    RegPropGain    = 2'd0,
    RegIntegGain   = 2'd1,
    RegDerivGain   = 2'd2,
    RegWindupLimit = 2'd3
  } reg_idx_e;

  function automatic logic signed [DataW-1:0] sat32(input logic signed [SumW-1:0] x);
    logic signed [DataW-1:0] r;
    if ((&x[SumW-1:DataW-1]) || !(|x[SumW-1:DataW-1])) begin
      r = x[DataW-1:0];
    end else if (x[SumW-1]) begin
      r = {1'b1, {(DataW-1){1'b0}}};
    end else begin
      r = {1'b0, {(DataW-1){1'b1}}};
    end
    return r;
  endfunction

endpackage

// ===== sv/mpid_in_if.sv =====
// Input channel: command, channel index, error sample and time step.
interface mpid_in_if;
  logic                                 valid;
  logic                                 ready;
  logic                                 cmd;
  logic        [mpid_pkg::ChanW-1:0]    channel;
  logic signed [mpid_pkg::DataW-1:0]    error_in;
  logic        [mpid_pkg::DtW-1:0]      time_step;

  modport source (output valid, cmd, channel, error_in, time_step, input ready);
  modport sink   (input valid, cmd, channel, error_in, time_step, output ready);
endinterface

// ===== sv/mpid_out_if.sv =====
// Output channel: saturated drive value and its channel index.
interface mpid_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [mpid_pkg::DataW-1:0]    drive;
  logic        [mpid_pkg::ChanW-1:0]    out_channel;

  modport source (output valid, drive, out_channel, input ready);
  modport sink   (input valid, drive, out_channel, output ready);
endinterface

// ===== sv/multichannel_pid_antiwindup_top.sv =====
// Multichannel PID controller with integral clamp, one shared multiplier and a radix-4 divider.
//
//  port       dir  carries
//  in_i       in   cmd, channel, error_in, time_step
//  out_o      out  drive, out_channel
//  cfg_*_i    in   gain / limit register writes
//
// A control step goes through read, load, integrate, clamp, the derivative divider (two
// quotient bits a cycle over a 48-bit dividend), fix-up, four passes through the shared
// 33x33 multiplier and write-back before its result shows. A zero time step skips the
// divider.
// A clear item, or one for a channel that does not exist, gives its result next cycle.
// Reset clears the entry valid bits at once; no clearing pass is needed.
// One item at a time: in_i is ready again the cycle after the result is taken on out_o.
module multichannel_pid_antiwindup_top #(
  parameter int unsigned CHANNELS = 8
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [mpid_pkg::RegIdxW-1:0]       cfg_idx_i,
  input  logic [mpid_pkg::DataW-1:0]         cfg_data_i,
  mpid_in_if.sink                            in_i,
  mpid_out_if.source                         out_o
);

  localparam int unsigned IdxW     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int unsigned DivW     = mpid_pkg::DataW + mpid_pkg::DtW;
  localparam int unsigned DivSteps = DivW / 2;
  localparam int unsigned CntW     = $clog2(DivSteps + 1);
  localparam int unsigned MulW     = mpid_pkg::DataW + 1;
  localparam int unsigned ProdW    = 2 * MulW;
  localparam int unsigned SumW     = mpid_pkg::SumW;
  localparam int unsigned DataW    = mpid_pkg::DataW;
  localparam int unsigned DtW      = mpid_pkg::DtW;

  typedef enum logic [3:0] {
    S_IDLE, S_READ, S_LOAD, S_INTEG, S_CLAMP, S_DIV, S_DFIX,
    S_MULP, S_MULI, S_MULD, S_ACC, S_WB, S_OUT
  } state_e;

  state_e state_q;
  logic [CntW-1:0]                  cnt_q;
  logic [CHANNELS-1:0]              vld_q;
  logic signed [DataW-1:0]          drive_q;
  logic [mpid_pkg::ChanW-1:0]       out_ch_q;

  logic signed [DataW-1:0]          kp_q, ki_q, kd_q;
  logic [mpid_pkg::LimW-1:0]        lim_q;

  // datapath
  logic [IdxW-1:0]                  idx_q;
  logic signed [DataW-1:0]          err_q;
  logic [DtW-1:0]                   dt_q;
  logic signed [DataW-1:0]          integ_q;
  logic signed [DataW-1:0]          deriv_q;
  logic                             neg_q;
  logic [DivW-1:0]                  div_q;
  logic [DtW-1:0]                   rem_q;
  logic signed [ProdW-1:0]          prod_q;
  logic signed [SumW-1:0]           acc_q;

  // channel state stores
  logic signed [DataW-1:0]          integ_mem [CHANNELS];
  logic signed [DataW-1:0]          last_mem  [CHANNELS];
  logic signed [DataW-1:0]          integ_rd_q, last_rd_q;
  logic                             vld_rd_q;

  logic                             in_range;
  logic                             mem_we;
  logic signed [MulW-1:0]           mul_a, mul_b;
  logic signed [ProdW-1:0]          prod_d;
  logic signed [SumW-1:0]           term;
  logic signed [DataW-1:0]          integ_old, last_old;
  logic signed [DataW:0]            diff;
  // magnitude of a 33-bit difference of two 32-bit values never exceeds 32 bits
  logic [DataW-1:0]                 diff_mag;
  logic signed [DataW:0]            integ_x, lim_x;
  logic [DivW-1:0]                  quo_d;
  logic [DtW-1:0]                   rem_d;

  assign in_range  = ({4'b0, in_i.channel} < 7'(CHANNELS));
  assign mem_we    = (state_q == S_WB);
  assign term      = prod_q[ProdW-1 -: SumW];
  assign integ_old = vld_rd_q ? integ_rd_q : '0;
  assign last_old  = vld_rd_q ? last_rd_q : '0;
  assign diff      = (DataW+1)'(err_q) - (DataW+1)'(last_old);
  assign diff_mag  = diff[DataW] ? DataW'(-diff) : DataW'(diff);
  assign integ_x   = (DataW+1)'(integ_q);
  assign lim_x     = signed'({2'b00, lim_q});

  assign in_i.ready        = (state_q == S_IDLE);
  assign out_o.valid       = (state_q == S_OUT);
  assign out_o.drive       = drive_q;
  assign out_o.out_channel = out_ch_q;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kp_q  <= '0;
      ki_q  <= '0;
      kd_q  <= '0;
      lim_q <= '0;
    end else if (cfg_we_i) begin
      case (mpid_pkg::reg_idx_e'(cfg_idx_i))
        mpid_pkg::RegPropGain:    kp_q  <= cfg_data_i;
        mpid_pkg::RegIntegGain:   ki_q  <= cfg_data_i;
        mpid_pkg::RegDerivGain:   kd_q  <= cfg_data_i;
        mpid_pkg::RegWindupLimit: lim_q <= cfg_data_i[mpid_pkg::LimW-1:0];
        default: ;
      endcase
    end
  end

  // shared multiplier operand select
  always_comb begin
    case (state_q)
      S_MULP: begin
        mul_a = MulW'(kp_q);
        mul_b = MulW'(err_q);
      end
      S_MULI: begin
        mul_a = MulW'(ki_q);
        mul_b = MulW'(integ_q);
      end
      S_MULD: begin
        mul_a = MulW'(kd_q);
        mul_b = MulW'(deriv_q);
      end
      default: begin
        mul_a = MulW'(err_q);
        mul_b = signed'({{(MulW-DtW){1'b0}}, dt_q});
      end
    endcase
    prod_d = mul_a * mul_b;
  end

  // two restoring division steps a cycle
  always_comb begin
    logic [DtW:0]    t;
    logic [DivW-1:0] q;
    logic [DtW-1:0]  r;
    q = div_q;
    r = rem_q;
    for (int k = 0; k < 2; k++) begin
      t = {r, q[DivW-1]};
      q = {q[DivW-2:0], 1'b0};
      if (t >= {1'b0, dt_q}) begin
        t    = t - {1'b0, dt_q};
        q[0] = 1'b1;
      end
      r = t[DtW-1:0];
    end
    quo_d = q;
    rem_d = r;
  end

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      cnt_q    <= '0;
      vld_q    <= '0;
      drive_q  <= '0;
      out_ch_q <= '0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (in_i.valid) begin
            out_ch_q <= in_i.channel;
            if (in_i.cmd == mpid_pkg::CmdClear) begin
              vld_q   <= '0;
              drive_q <= '0;
              state_q <= S_OUT;
            end else if (!in_range) begin
              drive_q <= '0;
              state_q <= S_OUT;
            end else begin
              state_q <= S_READ;
            end
          end
        end
        S_READ:  state_q <= S_LOAD;
        S_LOAD:  state_q <= S_INTEG;
        S_INTEG: state_q <= S_CLAMP;
        S_CLAMP: begin
          cnt_q   <= '0;
          state_q <= (dt_q == '0) ? S_DFIX : S_DIV;
        end
        S_DIV: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == CntW'(DivSteps - 1)) begin
            state_q <= S_DFIX;
          end
        end
        S_DFIX:  state_q <= S_MULP;
        S_MULP:  state_q <= S_MULI;
        S_MULI:  state_q <= S_MULD;
        S_MULD:  state_q <= S_ACC;
        S_ACC:   state_q <= S_WB;
        S_WB: begin
          drive_q      <= mpid_pkg::sat32(acc_q);
          vld_q[idx_q] <= 1'b1;
          state_q      <= S_OUT;
        end
        S_OUT: begin
          if (out_o.ready) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // arithmetic datapath
  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    case (state_q)
      S_IDLE: begin
        idx_q <= IdxW'(in_i.channel);
        err_q <= in_i.error_in;
        dt_q  <= in_i.time_step;
      end
      S_LOAD: begin
        integ_q <= integ_old;
        neg_q   <= diff[DataW];
        div_q   <= {diff_mag, {DtW{1'b0}}};
        rem_q   <= '0;
      end
      S_INTEG: integ_q <= mpid_pkg::sat32(SumW'(integ_q) + term);
      S_CLAMP: begin
        if (lim_q != '0) begin
          if (integ_x > lim_x) begin
            integ_q <= DataW'(lim_x);
          end else if (integ_x < -lim_x) begin
            integ_q <= DataW'(-lim_x);
          end
        end
      end
      S_DIV: begin
        div_q <= quo_d;
        rem_q <= rem_d;
      end
      S_DFIX: begin
        if (dt_q == '0) begin
          deriv_q <= '0;
        end else if (neg_q) begin
          if ((|div_q[DivW-1:DataW]) || (div_q[DataW-1] && (|div_q[DataW-2:0]))) begin
            deriv_q <= {1'b1, {(DataW-1){1'b0}}};
          end else begin
            deriv_q <= -signed'(div_q[DataW-1:0]);
          end
        end else begin
          if (|div_q[DivW-1:DataW-1]) begin
            deriv_q <= {1'b0, {(DataW-1){1'b1}}};
          end else begin
            deriv_q <= signed'(div_q[DataW-1:0]);
          end
        end
      end
      S_MULI:  acc_q <= term;
      S_MULD:  acc_q <= acc_q + term;
      S_ACC:   acc_q <= acc_q + term;
      default: ;
    endcase
  end

  // channel stores, registered read
  always_ff @(posedge clk_i) begin
    integ_rd_q <= integ_mem[idx_q];
    last_rd_q  <= last_mem[idx_q];
    vld_rd_q   <= vld_q[idx_q];
    if (mem_we) begin
      integ_mem[idx_q] <= integ_q;
      last_mem[idx_q]  <= err_q;
    end
  end

  a_ready_xor_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_i.ready && out_o.valid))
    else $error("input ready while a result is pending");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> !in_i.ready)
    else $error("accepted a second item while busy");

  a_clear_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready && in_i.cmd == mpid_pkg::CmdClear) |=> (vld_q == '0))
    else $error("clear item left channel state valid");

  a_div_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV) |-> (dt_q != '0))
    else $error("divider running with zero time step");

endmodule

// ===== tb/multichannel_pid_antiwindup_top_test.sv =====
// Self-checking testbench for the multichannel PID controller with integral clamp.
`timescale 1ns / 100ps

module multichannel_pid_antiwindup_top_test;

  localparam int NumChannels = 8;
  localparam int CycleLimit  = 800_000;
  localparam int HoldCycles  = 400;
  localparam int DrainCycles = 40;
  localparam int MaxPrinted  = 50;
  localparam longint Q16Max  = 64'sd2147483647;
  localparam longint Q16Min  = -64'sd2147483648;

  typedef struct packed {
    logic signed [mpid_pkg::DataW-1:0] drive;
    logic [mpid_pkg::ChanW-1:0]        chan;
  } pid_result_t;

  logic                         clk_i;
  logic                         rst_ni;
  logic                         cfg_we_i;
  logic [mpid_pkg::RegIdxW-1:0] cfg_idx_i;
  logic [mpid_pkg::DataW-1:0]   cfg_data_i;

  mpid_in_if  in_if ();
  mpid_out_if out_if ();

  multichannel_pid_antiwindup_top #(.CHANNELS(NumChannels)) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (in_if),
    .out_o      (out_if)
  );

  // predictor state: gains, clamp and per-channel stores
  logic signed [mpid_pkg::DataW-1:0] kp_q = '0;
  logic signed [mpid_pkg::DataW-1:0] ki_q = '0;
  logic signed [mpid_pkg::DataW-1:0] kd_q = '0;
  logic [mpid_pkg::LimW-1:0]         clamp_q = '0;
  logic signed [mpid_pkg::DataW-1:0] integ_mem [NumChannels];
  logic signed [mpid_pkg::DataW-1:0] last_err_mem [NumChannels];

  pid_result_t drive_q [$];
  int          error_count = 0;
  int          cycle_count = 0;
  bit          idle_en = 1'b1;
  bit          hold_req = 1'b0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  function automatic longint clip_q16(input longint x);
    if (x > Q16Max) return Q16Max;
    if (x < Q16Min) return Q16Min;
    return x;
  endfunction

  function automatic void clear_channels();
    for (int i = 0; i < NumChannels; i++) begin
      integ_mem[i]    = '0;
      last_err_mem[i] = '0;
    end
  endfunction

  function automatic pid_result_t predict_drive(input mpid_pkg::cmd_e cmd,
                                                input logic [mpid_pkg::ChanW-1:0] ch,
                                                input logic signed [mpid_pkg::DataW-1:0] err,
                                                input logic [mpid_pkg::DtW-1:0] dt);
    longint      integ;
    longint      deriv;
    longint      sum;
    pid_result_t r;
    r.chan  = ch;
    r.drive = '0;
    if (cmd == mpid_pkg::CmdClear) begin
      clear_channels();
    end else if (int'(ch) < NumChannels) begin
      integ = clip_q16(longint'(integ_mem[ch]) + ((longint'(err) * longint'(dt)) >>> 16));
      if (clamp_q != 0) begin
        if (integ > longint'(clamp_q)) integ = longint'(clamp_q);
        if (integ < -longint'(clamp_q)) integ = -longint'(clamp_q);
      end
      integ_mem[ch] = integ[mpid_pkg::DataW-1:0];
      deriv = 0;
      // zero time step: no derivative, but the previous error still moves on
      if (dt != 0) begin
        deriv = clip_q16(((longint'(err) - longint'(last_err_mem[ch])) * 65536)
                         / longint'(dt));
      end
      last_err_mem[ch] = err;
      sum = ((longint'(kp_q) * longint'(err)) >>> 16)
          + ((longint'(ki_q) * integ) >>> 16)
          + ((longint'(kd_q) * deriv) >>> 16);
      r.drive = mpid_pkg::DataW'(clip_q16(sum));
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    if (error_count < MaxPrinted) begin
      $display("%0t mismatch on %s: got %0d, want %0d", $realtime, what, got, want);
    end
    error_count++;
  endtask

  always @(posedge clk_i) begin : check_results
    pid_result_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (drive_q.size() == 0) begin
        report_mismatch("unexpected item", out_if.drive, 0);
      end else begin
        want = drive_q.pop_front();
        if (out_if.drive !== want.drive) report_mismatch("drive", out_if.drive, want.drive);
        if (out_if.out_channel !== want.chan) begin
          report_mismatch("out_channel", out_if.out_channel, want.chan);
        end
      end
    end
  end

  // receiver: random stalls, or a long hold-off on request
  initial begin : drive_ready
    int stall_left;
    stall_left = 0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req   = 1'b0;
        stall_left = HoldCycles;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= !(idle_en && $urandom_range(0, 99) < 28);
      end
    end
  end

  task automatic send_item(input mpid_pkg::cmd_e cmd, input logic [mpid_pkg::ChanW-1:0] ch,
                           input logic [mpid_pkg::DataW-1:0] err,
                           input logic [mpid_pkg::DtW-1:0] dt);
    int gap;
    if (idle_en && $urandom_range(0, 99) < 28) begin
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 45) : $urandom_range(1, 4);
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid     <= 1'b1;
    in_if.cmd       <= cmd;
    in_if.channel   <= ch;
    in_if.error_in  <= err;
    in_if.time_step <= dt;
    do @(posedge clk_i); while (!(in_if.valid && in_if.ready));
    drive_q.push_back(predict_drive(cmd, ch, err, dt));
  endtask

  // called right after an item is taken: drop valid, wait for every result
  task automatic drain();
    in_if.valid <= 1'b0;
    while (drive_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic program_gains(input logic [mpid_pkg::DataW-1:0] p,
                               input logic [mpid_pkg::DataW-1:0] i,
                               input logic [mpid_pkg::DataW-1:0] d,
                               input logic [mpid_pkg::DataW-1:0] lim);
    mpid_pkg::reg_idx_e         regs [4] = '{mpid_pkg::RegPropGain, mpid_pkg::RegIntegGain,
                                             mpid_pkg::RegDerivGain,
                                             mpid_pkg::RegWindupLimit};
    logic [mpid_pkg::DataW-1:0] vals [4];
    vals = '{p, i, d, lim};
    drain();
    for (int k = 0; k < 4; k++) begin
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= regs[k];
      cfg_data_i <= vals[k];
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
    kp_q    = p;
    ki_q    = i;
    kd_q    = d;
    clamp_q = lim[mpid_pkg::LimW-1:0];
  endtask

  function automatic logic [mpid_pkg::DataW-1:0] rand_error();
    case ($urandom_range(0, 9))
      0: return $urandom;
      1: begin
        case ($urandom_range(0, 4))
          0: return 32'h7FFF_FFFF;
          1: return 32'h8000_0000;
          2: return 32'h0000_0000;
          3: return 32'hFFFF_FFFF;
          default: return 32'h0000_0001;
        endcase
      end
      default: return $urandom_range(0, 32'h0010_0000) - 32'h0008_0000;
    endcase
  endfunction

  function automatic logic [mpid_pkg::DtW-1:0] rand_dt();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return 16'hFFFF;
      2: return 16'h0001;
      default: return mpid_pkg::DtW'($urandom_range(1, 16'hFFFF));
    endcase
  endfunction

  // gains within +-3.0 unless wide
  function automatic logic [mpid_pkg::DataW-1:0] rand_gain(input bit wide);
    if (wide) return $urandom;
    return $urandom_range(0, 32'h0006_0000) - 32'h0003_0000;
  endfunction

  // runs of steps on one channel, with an occasional clear item, so integrals build up against the clamp
  task automatic run_random_phase(input int count);
    int                         sent;
    int                         run_len;
    logic [mpid_pkg::ChanW-1:0] ch;
    sent = 0;
    while (sent < count) begin
      ch      = mpid_pkg::ChanW'($urandom_range(0, NumChannels - 1));
      run_len = $urandom_range(1, 10);
      repeat (run_len) begin
        if ($urandom_range(0, 99) < 2) begin
          send_item(mpid_pkg::CmdClear, mpid_pkg::ChanW'($urandom), $urandom,
                    mpid_pkg::DtW'($urandom));
        end else begin
          send_item(mpid_pkg::CmdStep, ch, rand_error(), rand_dt());
        end
        sent++;
      end
    end
  endtask

  task automatic test_proportional();
    program_gains(32'h0001_0000, 32'h0, 32'h0, 32'h0);
    send_item(mpid_pkg::CmdStep, 3'd0, 32'h7FFF_FFFF, 16'hFFFF);
    send_item(mpid_pkg::CmdStep, 3'd7, 32'h8000_0000, 16'h0001);
    program_gains(32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'h0);
    send_item(mpid_pkg::CmdStep, 3'd1, 32'h8000_0000, 16'h0001);
    send_item(mpid_pkg::CmdStep, 3'd1, 32'h7FFF_FFFF, 16'hFFFF);
  endtask

  task automatic test_integral_clamp();
    program_gains(32'h0, 32'h0001_0000, 32'h0, 32'h0003_0000);
    send_item(mpid_pkg::CmdStep, 3'd3, 32'h7FFF_FFFF, 16'hFFFF);
    send_item(mpid_pkg::CmdStep, 3'd3, 32'h7FFF_FFFF, 16'hFFFF);
    send_item(mpid_pkg::CmdStep, 3'd3, 32'h8000_0000, 16'hFFFF);
    send_item(mpid_pkg::CmdStep, 3'd3, 32'h8000_0000, 16'hFFFF);
    // no clamp: the integral itself saturates
    program_gains(32'h0, 32'h0001_0000, 32'h0, 32'h0);
    repeat (3) send_item(mpid_pkg::CmdStep, 3'd5, 32'h7FFF_FFFF, 16'hFFFF);
  endtask

  task automatic test_derivative();
    program_gains(32'h0, 32'h0, 32'h7FFF_FFFF, 32'h0);
    send_item(mpid_pkg::CmdStep, 3'd2, 32'h7FFF_FFFF, 16'h0001);
    send_item(mpid_pkg::CmdStep, 3'd2, 32'h8000_0000, 16'h0001);
    program_gains(32'h0, 32'h0, 32'h0001_0000, 32'h0);
    send_item(mpid_pkg::CmdStep, 3'd2, 32'h0000_0005, 16'h0003);
    send_item(mpid_pkg::CmdStep, 3'd2, 32'hFFFF_FFFA, 16'h0003);
  endtask

  task automatic test_zero_time_step();
    program_gains(32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 32'h0);
    send_item(mpid_pkg::CmdStep, 3'd1, 32'h0005_0000, 16'h0000);
    send_item(mpid_pkg::CmdStep, 3'd1, 32'hFFFE_0000, 16'h0000);
    send_item(mpid_pkg::CmdStep, 3'd1, 32'h0001_0000, 16'h8000);
  endtask

  task automatic test_clear();
    program_gains(32'h0000_8000, 32'h0002_0000, 32'h0001_8000, 32'h0);
    send_item(mpid_pkg::CmdStep, 3'd4, 32'h0004_0000, 16'h4000);
    send_item(mpid_pkg::CmdClear, 3'd6, 32'h1234_5678, 16'h00A5);
    send_item(mpid_pkg::CmdStep, 3'd4, 32'h0004_0000, 16'h4000);
    send_item(mpid_pkg::CmdClear, 3'd7, 32'hFFFF_FFFF, 16'hFFFF);
  endtask

  task automatic test_backpressure();
    program_gains(rand_gain(0), rand_gain(0), rand_gain(0), 32'h0004_0000);
    hold_req = 1'b1;
    repeat (16) begin
      send_item(mpid_pkg::CmdStep, mpid_pkg::ChanW'($urandom), rand_error(), rand_dt());
    end
  endtask

  task automatic test_random();
    program_gains(rand_gain(0), rand_gain(0), rand_gain(0),
                  $urandom_range(32'h1000, 32'h0020_0000));
    run_random_phase(240);
    // all-ones limit: bit 31 is dropped, leaving the widest clamp
    program_gains(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
    run_random_phase(200);
    program_gains(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h0);
    run_random_phase(200);
    idle_en = 1'b0;
    program_gains(rand_gain(0), rand_gain(0), rand_gain(0),
                  $urandom_range(32'h8000, 32'h0008_0000));
    run_random_phase(280);
    idle_en = 1'b1;
    program_gains(rand_gain(1), rand_gain(1), rand_gain(1), $urandom);
    run_random_phase(240);
    program_gains(rand_gain(0), rand_gain(0), rand_gain(0), 32'h0);
    run_random_phase(280);
  endtask

  initial begin
    rst_ni          <= 1'b0;
    cfg_we_i        <= 1'b0;
    cfg_idx_i       <= mpid_pkg::RegPropGain;
    cfg_data_i      <= '0;
    in_if.valid     <= 1'b0;
    in_if.cmd       <= mpid_pkg::CmdStep;
    in_if.channel   <= '0;
    in_if.error_in  <= '0;
    in_if.time_step <= '0;
    clear_channels();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_proportional();
    test_integral_clamp();
    test_derivative();
    test_zero_time_step();
    test_clear();
    test_backpressure();
    test_random();

    drain();
    repeat (DrainCycles) @(posedge clk_i);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
